FILE: rtl/sitp_pkg.sv
package sitp_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned RADIX_W = 6;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned POS_W   = 16;
	localparam int unsigned PROD_W  = VALUE_W + RADIX_W;

	localparam logic [POS_W-1:0] MAX_POS = 16'hFFFF;

	localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VALUE_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

	localparam logic [RADIX_W-1:0] BASE_OCT = 6'd8;
	localparam logic [RADIX_W-1:0] BASE_DEC = 6'd10;
	localparam logic [RADIX_W-1:0] BASE_HEX = 6'd16;

	typedef enum logic [1:0] {
		BASE_HOLD,
		BASE_PREFIX,
		BASE_PLAIN,
		BASE_FORCE_HEX
	} base_op_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_DIGIT,
		ACC_MAC
	} acc_op_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_ACC,
		RES_LIMIT
	} res_sel_t;

	typedef enum logic [1:0] {
		END_ZERO,
		END_IDX,
		END_IDX_M1
	} end_sel_t;

	typedef struct packed {
		logic     new_str;
		logic     pos_inc;
		logic     neg_load;
		base_op_t base_op;
		acc_op_t  acc_op;
		logic     emit;
		res_sel_t res_sel;
		end_sel_t end_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic nul;
		logic blank;
		logic sign;
		logic zero_char;
		logic x_char;
		logic radix_pfx;
		logic dig_ok_new;
		logic dig_ok_eff;
		logic dig_hex;
		logic mac_ovf;
	} dp_status_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   end_index;
		logic               overflow;
	} result_t;

	// digit value of an alphanumeric character; bit 6 flags a valid digit
	function automatic logic [RADIX_W:0] digit_of(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] t;
		logic [RADIX_W:0]  r;
		r = '0;
		t = '0;
		if (c >= CH_0 && c <= CH_9) begin
			t = c - CH_0;
			r = {1'b1, t[RADIX_W-1:0]};
		end else if (c >= CH_LA && c <= CH_LZ) begin
			t = c - CH_LA + 8'd10;
			r = {1'b1, t[RADIX_W-1:0]};
		end else if (c >= CH_UA && c <= CH_UZ) begin
			t = c - CH_UA + 8'd10;
			r = {1'b1, t[RADIX_W-1:0]};
		end
		return r;
	endfunction

endpackage

FILE: rtl/signed_integer_text_parser_top.sv
// Streaming signed integer text parser, strtol style.
// Input channel: one character per beat (char_code, in_valid/in_ready); a
// zero byte ends the string. Leading blanks, one sign, then an optional
// 0x/0 prefix (radix 0 auto-detects, radix 16 skips 0x) and digits below
// the base are taken.
// Output channel: one beat per string (value, end_index, overflow,
// out_valid/out_ready), issued on the first character that is not part of
// the number. Overflow saturates value to the signed 64-bit limit.
// Configuration: cfg_we/cfg_data write the radix; write only while idle.
// Throughput: one character per clock while in_ready is high. Per-digit
// multiply-add (64 x 6 bit product, add, limit compare) is combinational.
// Output: the ending beat's result is registered in the head or skid entry.
// Stall: a two-entry output buffer holds results; in_ready drops only
// when both entries are occupied and returns as the receiver takes one.
// Reset: clears the radix to 0 (automatic), the parse state and both
// output entries; no clearing pass is needed.
module signed_integer_text_parser_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sitp_pkg::RADIX_W-1:0]        cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sitp_pkg::CHAR_W-1:0]         char_code,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sitp_pkg::VALUE_W-1:0] value,
	output logic [sitp_pkg::POS_W-1:0]          end_index,
	output logic                                overflow
);

	logic                 in_fire;
	logic                 buf_full;
	sitp_pkg::dp_cmd_t    cmd;
	sitp_pkg::dp_status_t status;
	sitp_pkg::result_t    result;
	sitp_pkg::result_t    out_data;

	assign in_ready = !buf_full;
	assign in_fire  = in_valid && in_ready;

	// phase sequencing
	sitp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.status  (status),
		.cmd     (cmd)
	);

	// radix, accumulator, position, sign and classification
	sitp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.char_code (char_code),
		.in_fire   (in_fire),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

	// result register plus skid entry
	sitp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd.emit),
		.push_data (result),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign value     = signed'(out_data.value);
	assign end_index = out_data.end_index;
	assign overflow  = out_data.overflow;

	// a result is only produced by an accepted beat
	a_emit_on_fire : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> in_fire)
		else $error("result issued without an accepted beat");

	// the skid entry only fills behind a waiting head
	a_skid_behind_head : assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("skid entry occupied with empty head");

	// a saturated result carries one of the two limits
	a_ovf_limit : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |->
		(out_data.value == sitp_pkg::POS_LIMIT || out_data.value == sitp_pkg::NEG_LIMIT))
		else $error("overflow flagged without saturated value");

	// a stalled head beat is not overwritten by a new result
	a_head_held : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && cmd.emit) |=> (out_valid && !in_ready))
		else $error("result lost while receiver stalled");

endmodule

FILE: rtl/sitp_dp.sv
module sitp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sitp_pkg::RADIX_W-1:0]  cfg_data,
	input  logic [sitp_pkg::CHAR_W-1:0]   char_code,
	input  logic                          in_fire,
	input  sitp_pkg::dp_cmd_t             cmd,
	output sitp_pkg::dp_status_t          status,
	output sitp_pkg::result_t             result
);

	logic [sitp_pkg::RADIX_W-1:0] radix_q;
	logic [sitp_pkg::RADIX_W-1:0] base_q;
	logic [sitp_pkg::VALUE_W-1:0] acc_q;
	logic [sitp_pkg::POS_W-1:0]   pos_q;
	logic                         neg_q;

	logic [sitp_pkg::RADIX_W:0]   dig;
	logic                         dvalid;
	logic [sitp_pkg::RADIX_W-1:0] dval;
	logic [sitp_pkg::RADIX_W-1:0] new_base;
	logic [sitp_pkg::RADIX_W-1:0] pfx_base;
	logic [sitp_pkg::PROD_W-1:0]  prod;
	logic [sitp_pkg::PROD_W-1:0]  mac_sum;
	logic [sitp_pkg::PROD_W-1:0]  limit_w;
	logic [sitp_pkg::VALUE_W-1:0] mag;

	assign dig    = sitp_pkg::digit_of(char_code);
	assign dvalid = dig[sitp_pkg::RADIX_W];
	assign dval   = dig[sitp_pkg::RADIX_W-1:0];

	assign new_base = (radix_q == '0) ? sitp_pkg::BASE_DEC : radix_q;
	assign pfx_base = (radix_q == '0) ? sitp_pkg::BASE_OCT : sitp_pkg::BASE_HEX;

	// acc never exceeds 2^63 and base stays below 64, so the sum fits
	assign prod    = sitp_pkg::PROD_W'(acc_q) * sitp_pkg::PROD_W'(base_q);
	assign mac_sum = prod + sitp_pkg::PROD_W'(dval);
	assign limit_w = neg_q ? sitp_pkg::PROD_W'(sitp_pkg::NEG_LIMIT)
	                       : sitp_pkg::PROD_W'(sitp_pkg::POS_LIMIT);

	always_comb begin
		status.nul        = (char_code == sitp_pkg::CH_NUL);
		status.blank      = (char_code == sitp_pkg::CH_SPACE) ||
		                    (char_code >= sitp_pkg::CH_TAB && char_code <= sitp_pkg::CH_CR);
		status.sign       = (char_code == sitp_pkg::CH_PLUS) ||
		                    (char_code == sitp_pkg::CH_MINUS);
		status.zero_char  = (char_code == sitp_pkg::CH_0);
		status.x_char     = (char_code == sitp_pkg::CH_LX) || (char_code == sitp_pkg::CH_UX);
		status.radix_pfx  = (radix_q == '0) || (radix_q == sitp_pkg::BASE_HEX);
		status.dig_ok_new = dvalid && (dval < new_base);
		status.dig_ok_eff = dvalid && (dval < base_q) && (base_q != '0);
		status.dig_hex    = dvalid && (dval < sitp_pkg::BASE_HEX);
		status.mac_ovf    = (mac_sum > limit_w);
	end

	always_comb begin
		unique case (cmd.res_sel)
			sitp_pkg::RES_ACC:   mag = acc_q;
			sitp_pkg::RES_LIMIT: mag = limit_w[sitp_pkg::VALUE_W-1:0];
			default:             mag = '0;
		endcase
		result.value    = neg_q ? (~mag + 64'd1) : mag;
		result.overflow = (cmd.res_sel == sitp_pkg::RES_LIMIT);
		unique case (cmd.end_sel)
			sitp_pkg::END_IDX:    result.end_index = pos_q;
			sitp_pkg::END_IDX_M1: result.end_index = (pos_q == '0) ? '0 : pos_q - 16'd1;
			default:              result.end_index = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= '0;
		end else if (cfg_we) begin
			radix_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			acc_q  <= '0;
			pos_q  <= '0;
			neg_q  <= 1'b0;
		end else if (in_fire) begin
			if (cmd.new_str) begin
				base_q <= '0;
				acc_q  <= '0;
				pos_q  <= '0;
				neg_q  <= 1'b0;
			end else begin
				if (cmd.pos_inc && pos_q != sitp_pkg::MAX_POS) begin
					pos_q <= pos_q + 16'd1;
				end
				if (cmd.neg_load) begin
					neg_q <= (char_code == sitp_pkg::CH_MINUS);
				end
				unique case (cmd.base_op)
					sitp_pkg::BASE_PREFIX:    base_q <= pfx_base;
					sitp_pkg::BASE_PLAIN:     base_q <= new_base;
					sitp_pkg::BASE_FORCE_HEX: base_q <= sitp_pkg::BASE_HEX;
					default:                  base_q <= base_q;
				endcase
				unique case (cmd.acc_op)
					sitp_pkg::ACC_DIGIT: acc_q <= sitp_pkg::VALUE_W'(dval);
					sitp_pkg::ACC_MAC:   acc_q <= mac_sum[sitp_pkg::VALUE_W-1:0];
					default:             acc_q <= acc_q;
				endcase
			end
		end
	end

endmodule

FILE: rtl/sitp_ctrl.sv
module sitp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  sitp_pkg::dp_status_t status,
	output sitp_pkg::dp_cmd_t    cmd
);

	localparam logic [2:0] PH_BLANK  = 3'd0;
	localparam logic [2:0] PH_SIGNED = 3'd1;
	localparam logic [2:0] PH_ZERO   = 3'd2;
	localparam logic [2:0] PH_HEXX   = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	logic [2:0] phase_q;
	logic [2:0] phase_d;

	always_comb begin
		cmd         = '0;
		cmd.base_op = sitp_pkg::BASE_HOLD;
		cmd.acc_op  = sitp_pkg::ACC_HOLD;
		cmd.res_sel = sitp_pkg::RES_ZERO;
		cmd.end_sel = sitp_pkg::END_ZERO;
		phase_d     = phase_q;
		if (in_fire) begin
			cmd.pos_inc = (phase_q != PH_DONE);
			unique case (phase_q)
				PH_BLANK, PH_SIGNED: begin
					if (phase_q == PH_BLANK && status.blank) begin
						phase_d = PH_BLANK;
					end else if (phase_q == PH_BLANK && status.sign) begin
						cmd.neg_load = 1'b1;
						phase_d      = PH_SIGNED;
					end else if (status.zero_char && status.radix_pfx) begin
						cmd.base_op = sitp_pkg::BASE_PREFIX;
						phase_d     = PH_ZERO;
					end else begin
						cmd.base_op = sitp_pkg::BASE_PLAIN;
						if (status.dig_ok_new) begin
							cmd.acc_op = sitp_pkg::ACC_DIGIT;
							phase_d    = PH_DIGITS;
						end else begin
							cmd.emit = 1'b1;
						end
					end
				end
				PH_ZERO: begin
					if (status.x_char) begin
						cmd.base_op = sitp_pkg::BASE_FORCE_HEX;
						phase_d     = PH_HEXX;
					end else if (!status.dig_ok_eff) begin
						cmd.emit    = 1'b1;
						cmd.res_sel = sitp_pkg::RES_ACC;
						cmd.end_sel = sitp_pkg::END_IDX;
					end else if (status.mac_ovf) begin
						cmd.emit    = 1'b1;
						cmd.res_sel = sitp_pkg::RES_LIMIT;
						cmd.end_sel = sitp_pkg::END_IDX;
					end else begin
						cmd.acc_op = sitp_pkg::ACC_MAC;
						phase_d    = PH_DIGITS;
					end
				end
				PH_HEXX: begin
					if (status.dig_hex) begin
						cmd.acc_op = sitp_pkg::ACC_DIGIT;
						phase_d    = PH_DIGITS;
					end else begin
						// bare prefix: the x is given back
						cmd.emit    = 1'b1;
						cmd.end_sel = sitp_pkg::END_IDX_M1;
					end
				end
				PH_DIGITS: begin
					if (!status.dig_ok_eff) begin
						cmd.emit    = 1'b1;
						cmd.res_sel = sitp_pkg::RES_ACC;
						cmd.end_sel = sitp_pkg::END_IDX;
					end else if (status.mac_ovf) begin
						cmd.emit    = 1'b1;
						cmd.res_sel = sitp_pkg::RES_LIMIT;
						cmd.end_sel = sitp_pkg::END_IDX;
					end else begin
						cmd.acc_op = sitp_pkg::ACC_MAC;
					end
				end
				PH_DONE: begin
					if (status.nul) begin
						cmd.new_str = 1'b1;
						phase_d     = PH_BLANK;
					end
				end
				default: begin
					cmd.new_str = 1'b1;
					phase_d     = PH_BLANK;
				end
			endcase
			if (cmd.emit) begin
				cmd.new_str = status.nul;
				phase_d     = status.nul ? PH_BLANK : PH_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BLANK;
		end else begin
			phase_q <= phase_d;
		end
	end

endmodule

FILE: rtl/sitp_outbuf.sv
module sitp_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sitp_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_ready,
	output sitp_pkg::result_t out_data
);

	logic              head_valid_q;
	logic              skid_valid_q;
	sitp_pkg::result_t head_q;
	sitp_pkg::result_t skid_q;
	logic              head_free;

	assign head_free = !head_valid_q || out_ready;
	assign full      = skid_valid_q;
	assign out_valid = head_valid_q;
	assign out_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (head_free) begin
			if (skid_valid_q) begin
				head_valid_q <= 1'b1;
				skid_valid_q <= push;
			end else begin
				head_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (head_free) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

FILE: dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// run shape
	localparam int RAND_ITEMS  = 1200;   // characters sent in the random part
	localparam int PHASE_ITEMS = 100;    // characters between radix changes
	localparam int HOLD_CYCLES = 150;    // long receiver hold-off, fills the output buffer
	localparam int SETTLE      = 4;      // cycles after the last result before a radix write

	// clock, reset and block ports
	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                cfg_we    = 1'b0;
	logic [sitp_pkg::RADIX_W-1:0]        cfg_data  = '0;
	logic                                in_valid  = 1'b0;
	logic                                in_ready;
	logic [sitp_pkg::CHAR_W-1:0]         char_code = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic signed [sitp_pkg::VALUE_W-1:0] value;
	logic [sitp_pkg::POS_W-1:0]          end_index;
	logic                                overflow;

	signed_integer_text_parser_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.end_index (end_index),
		.overflow  (overflow)
	);

	// 20 ns period
	initial begin
		forever #10 clk = ~clk;
	end

	// generous fixed limit: the slowest legal run is well under a tenth of this
	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor: own copy of the parse state, stepped once per input beat
	// ------------------------------------------------------------------
	typedef enum logic [2:0] {
		SCAN_BLANK,    // skipping leading blanks
		SCAN_SIGN,     // sign taken, first significant char next
		SCAN_ZERO,     // a leading zero that may open a 0x prefix
		SCAN_HEX_X,    // 0x seen, first hex digit next
		SCAN_DIGITS,   // accumulating
		SCAN_DONE      // result issued, ignore until the zero byte
	} scan_phase_t;

	scan_phase_t                  m_phase;
	logic                         m_neg;
	logic [sitp_pkg::VALUE_W-1:0] m_acc;
	logic [sitp_pkg::POS_W-1:0]   m_pos;
	logic [sitp_pkg::RADIX_W-1:0] m_base;       // latched at the first significant char
	logic                         m_zero_pend;
	logic [sitp_pkg::RADIX_W-1:0] m_radix;

	sitp_pkg::result_t parsed_q[$];             // parsed numbers still owed by the block

	function automatic void clear_string();
		m_phase     = SCAN_BLANK;
		m_neg       = 1'b0;
		m_acc       = '0;
		m_pos       = '0;
		m_base      = '0;
		m_zero_pend = 1'b0;
	endfunction

	// -1 for anything that is not 0-9, a-z, A-Z
	function automatic int char_digit(input logic [sitp_pkg::CHAR_W-1:0] c);
		if (c >= sitp_pkg::CH_0 && c <= sitp_pkg::CH_9)
			return c - sitp_pkg::CH_0;
		if (c >= sitp_pkg::CH_LA && c <= sitp_pkg::CH_LZ)
			return c - sitp_pkg::CH_LA + 10;
		if (c >= sitp_pkg::CH_UA && c <= sitp_pkg::CH_UZ)
			return c - sitp_pkg::CH_UA + 10;
		return -1;
	endfunction

	function automatic bit finish_number(input logic [sitp_pkg::VALUE_W-1:0] mag,
			input logic [sitp_pkg::POS_W-1:0] idx, input logic ovf,
			input logic [sitp_pkg::CHAR_W-1:0] c, output sitp_pkg::result_t res);
		res.value     = m_neg ? -mag : mag;
		res.end_index = idx;
		res.overflow  = ovf;
		if (c == sitp_pkg::CH_NUL)
			clear_string();
		else
			m_phase = SCAN_DONE;
		return 1'b1;
	endfunction

	function automatic bit take_digit(input logic [sitp_pkg::CHAR_W-1:0] c,
			input logic [sitp_pkg::POS_W-1:0] idx, output sitp_pkg::result_t res);
		int                           d;
		logic [sitp_pkg::VALUE_W-1:0] lim;
		logic [sitp_pkg::VALUE_W-1:0] b;
		logic [sitp_pkg::VALUE_W-1:0] q;
		logic [sitp_pkg::VALUE_W-1:0] r;
		d   = char_digit(c);
		b   = sitp_pkg::VALUE_W'(m_base);
		lim = m_neg ? sitp_pkg::NEG_LIMIT : sitp_pkg::POS_LIMIT;
		if (d < 0 || d >= m_base || m_base == 0)
			return finish_number(m_acc, idx, 1'b0, c, res);
		q = lim / b;
		r = lim % b;
		// would the next multiply-add pass the limit: saturate and stop here
		if (m_acc > q || (m_acc == q && d > r))
			return finish_number(lim, idx, 1'b1, c, res);
		m_acc = m_acc * b + sitp_pkg::VALUE_W'(d);
		return 1'b0;
	endfunction

	function automatic bit parse_char(input logic [sitp_pkg::CHAR_W-1:0] c,
			output sitp_pkg::result_t res);
		logic [sitp_pkg::POS_W-1:0] idx;
		int                         d;
		res = '0;
		idx = m_pos;
		if (m_phase == SCAN_DONE) begin
			if (c == sitp_pkg::CH_NUL)
				clear_string();
			return 1'b0;
		end
		if (m_pos != sitp_pkg::MAX_POS)
			m_pos++;
		case (m_phase)
			SCAN_BLANK, SCAN_SIGN: begin
				if (m_phase == SCAN_BLANK) begin
					if (c == sitp_pkg::CH_SPACE ||
							(c >= sitp_pkg::CH_TAB && c <= sitp_pkg::CH_CR))
						return 1'b0;
					if (c == sitp_pkg::CH_PLUS || c == sitp_pkg::CH_MINUS) begin
						m_neg   = (c == sitp_pkg::CH_MINUS);
						m_phase = SCAN_SIGN;
						return 1'b0;
					end
				end
				if (c == sitp_pkg::CH_0 && (m_radix == 0 || m_radix == sitp_pkg::BASE_HEX)) begin
					m_zero_pend = 1'b1;
					m_base      = (m_radix == 0) ? sitp_pkg::BASE_OCT : sitp_pkg::BASE_HEX;
					m_phase     = SCAN_ZERO;
					return 1'b0;
				end
				m_base = (m_radix == 0) ? sitp_pkg::BASE_DEC : m_radix;
				d      = char_digit(c);
				if (d >= 0 && d < m_base) begin
					m_acc   = sitp_pkg::VALUE_W'(d);
					m_phase = SCAN_DIGITS;
					return 1'b0;
				end
				return finish_number('0, '0, 1'b0, c, res);
			end
			SCAN_ZERO: begin
				m_zero_pend = 1'b0;
				if (c == sitp_pkg::CH_LX || c == sitp_pkg::CH_UX) begin
					m_base  = sitp_pkg::BASE_HEX;
					m_phase = SCAN_HEX_X;
					return 1'b0;
				end
				m_phase = SCAN_DIGITS;
				return take_digit(c, idx, res);
			end
			SCAN_HEX_X: begin
				d = char_digit(c);
				if (d >= 0 && d < sitp_pkg::BASE_HEX) begin
					m_acc   = sitp_pkg::VALUE_W'(d);
					m_phase = SCAN_DIGITS;
					return 1'b0;
				end
				// bare prefix: the x is not consumed
				return finish_number('0, idx - 1'b1, 1'b0, c, res);
			end
			SCAN_DIGITS:
				return take_digit(c, idx, res);
			default: begin
				clear_string();
				return 1'b0;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Directed plan: rows walked in order; a pinned row carries a typed result
	// ------------------------------------------------------------------
	typedef struct {
		bit                          is_cfg;
		logic [sitp_pkg::CHAR_W-1:0] data;    // character, or radix on a cfg row
		bit                          pinned;
		sitp_pkg::result_t           res;
	} plan_row_t;

	typedef struct {
		bit                on;
		sitp_pkg::result_t res;
	} pin_t;

	plan_row_t plan[$];
	pin_t      pinned_q[$];          // one per directed character beat

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			plan.push_back('{1'b0, s[i], 1'b0, sitp_pkg::result_t'(0)});
	endfunction

	function automatic void add_pin(input logic [sitp_pkg::CHAR_W-1:0] c,
			input logic [sitp_pkg::VALUE_W-1:0] v,
			input logic [sitp_pkg::POS_W-1:0] e, input logic o);
		sitp_pkg::result_t r;
		r.value     = v;
		r.end_index = e;
		r.overflow  = o;
		plan.push_back('{1'b0, c, 1'b1, r});
	endfunction

	function automatic void add_cfg(input logic [sitp_pkg::RADIX_W-1:0] r);
		plan.push_back('{1'b1, sitp_pkg::CHAR_W'(r), 1'b0, sitp_pkg::result_t'(0)});
	endfunction

	// ------------------------------------------------------------------
	// Monitor: predicts on every input beat, checks every output beat
	// ------------------------------------------------------------------
	int mismatches = 0;

	always @(posedge clk) begin
		sitp_pkg::result_t got;
		sitp_pkg::result_t want;
		pin_t              pin;
		bit                made;
		if (!arst_n) begin
			m_radix = '0;
			clear_string();
		end else begin
			if (in_valid && in_ready) begin
				made = parse_char(char_code, want);
				if (pinned_q.size() != 0) begin
					pin = pinned_q.pop_front();
					if (pin.on) begin
						made = 1'b1;
						want = pin.res;
					end
				end
				if (made)
					parsed_q.push_back(want);
			end
			// the block parses with the radix held before this edge
			if (cfg_we)
				m_radix = cfg_data;
			if (out_valid && out_ready) begin
				got.value     = value;
				got.end_index = end_index;
				got.overflow  = overflow;
				if (parsed_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: value %0d end %0d ovf %0b",
							$signed(got.value), got.end_index, got.overflow);
				end else begin
					want = parsed_q.pop_front();
					if (got.value !== want.value || got.end_index !== want.end_index ||
							got.overflow !== want.overflow) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result mismatch: exp value %0d end %0d ovf %0b,",
								" got value %0d end %0d ovf %0b"},
								$signed(want.value), want.end_index, want.overflow,
								$signed(got.value), got.end_index, got.overflow);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off on request
	// ------------------------------------------------------------------
	int send_gap_pct = 27;
	int recv_gap_pct = 46;
	bit hold_req     = 1'b0;   // driver side only
	bit hold_done    = 1'b0;   // receiver side only
	int hold_left    = 0;

	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_gap_pct);
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	logic [sitp_pkg::RADIX_W-1:0] radix_now = '0;
	logic [sitp_pkg::CHAR_W-1:0]  text_q[$];       // characters of the string being built
	int                           counted = 0;     // characters sent in the random part

	// valid stays up across back-to-back beats; it drops only for a gap
	task automatic send_char(input logic [sitp_pkg::CHAR_W-1:0] c);
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop offering, wait for every owed result, then let the pipe settle
	task automatic drain(input int settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (parsed_q.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_radix(input logic [sitp_pkg::RADIX_W-1:0] r);
		drain(SETTLE);
		cfg_we    <= 1'b1;
		cfg_data  <= r;
		radix_now  = r;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [sitp_pkg::CHAR_W-1:0] digit_char(input int d);
		if (d < 10)
			return sitp_pkg::CH_0 + sitp_pkg::CHAR_W'(d);
		return ($urandom_range(1) ? sitp_pkg::CH_UA : sitp_pkg::CH_LA) +
			sitp_pkg::CHAR_W'(d - 10);
	endfunction

	function automatic logic [sitp_pkg::CHAR_W-1:0] blank_char();
		return ($urandom_range(3) == 0) ? sitp_pkg::CH_SPACE :
			sitp_pkg::CH_TAB + sitp_pkg::CHAR_W'($urandom_range(4));
	endfunction

	// mostly well-formed numbers with random content; some noise and broken ones
	task automatic build_string();
		int                           sel;
		int                           base;
		int                           cap;
		int                           n;
		bit                           neg;
		logic [sitp_pkg::VALUE_W-1:0] mag;
		logic [sitp_pkg::CHAR_W-1:0]  rev[$];
		text_q.delete();
		sel = $urandom_range(99);
		if (sel < 15) begin
			n = $urandom_range(6);
			repeat (n) text_q.push_back(sitp_pkg::CHAR_W'($urandom_range(255, 1)));
		end else begin
			repeat ($urandom_range(2)) text_q.push_back(blank_char());
			sel = $urandom_range(2);
			neg = (sel == 2);
			if (sel == 1)
				text_q.push_back(sitp_pkg::CH_PLUS);
			if (sel == 2)
				text_q.push_back(sitp_pkg::CH_MINUS);
			// broken: a second sign or a blank straight after the sign
			if (sel != 0 && $urandom_range(19) == 0)
				text_q.push_back($urandom_range(1) ? sitp_pkg::CH_MINUS : sitp_pkg::CH_SPACE);
			base = radix_now;
			if (radix_now == 0 || radix_now == sitp_pkg::BASE_HEX) begin
				sel = $urandom_range(2);
				if (sel == 1) begin
					text_q.push_back(sitp_pkg::CH_0);
					text_q.push_back($urandom_range(1) ? sitp_pkg::CH_LX : sitp_pkg::CH_UX);
					base = sitp_pkg::BASE_HEX;
				end else if (sel == 2 && radix_now == 0) begin
					text_q.push_back(sitp_pkg::CH_0);
					base = sitp_pkg::BASE_OCT;
				end else if (radix_now == 0)
					base = sitp_pkg::BASE_DEC;
			end
			cap = (base > 36) ? 36 : base;
			if (base >= 2 && base <= 36 && $urandom_range(7) == 0) begin
				// right at the limit: one below, exact, one past
				mag = (neg ? sitp_pkg::NEG_LIMIT : sitp_pkg::POS_LIMIT) +
					sitp_pkg::VALUE_W'($urandom_range(2)) - 1'b1;
				while (mag != 0) begin
					rev.push_front(digit_char(int'(mag % base)));
					mag = mag / base;
				end
				foreach (rev[i])
					text_q.push_back(rev[i]);
			end else begin
				n = ($urandom_range(9) == 0) ? $urandom_range(24, 8) : $urandom_range(6);
				repeat (n) text_q.push_back(digit_char($urandom_range(cap - 1)));
			end
			// optional tail of random bytes, parsed or skipped as they come
			if ($urandom_range(1)) begin
				repeat ($urandom_range(4, 1))
					text_q.push_back(sitp_pkg::CHAR_W'($urandom_range(255, 1)));
			end
		end
		text_q.push_back(sitp_pkg::CH_NUL);
		counted += text_q.size();
	endtask

	// radix of the first random phases; later ones are drawn at random
	logic [sitp_pkg::RADIX_W-1:0] radix_plan [9] = '{6'd0, 6'd2, 6'd36, 6'd63, 6'd1,
		sitp_pkg::BASE_HEX, sitp_pkg::BASE_DEC, sitp_pkg::BASE_OCT, 6'd37};

	initial begin
		int phase_no;
		int phase_end;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed part, radix 0 out of reset ---
		add_pin(sitp_pkg::CH_NUL, '0, 16'd0, 1'b0);   // empty string, no conversion
		add_text("\t-0x");
		add_pin(sitp_pkg::CH_NUL, '0, 16'd3, 1'b0);   // bare 0x: x not consumed
		add_text("017");                              // octal by leading zero
		plan.push_back('{1'b0, sitp_pkg::CH_NUL, 1'b0, sitp_pkg::result_t'(0)});
		add_pin(8'hFF, '0, 16'd0, 1'b0);              // top byte, not a digit
		plan.push_back('{1'b0, sitp_pkg::CH_NUL, 1'b0, sitp_pkg::result_t'(0)});
		add_text("-");
		add_pin(sitp_pkg::CH_PLUS, '0, 16'd0, 1'b0);  // second sign ends it
		plan.push_back('{1'b0, sitp_pkg::CH_NUL, 1'b0, sitp_pkg::result_t'(0)});
		add_cfg(6'd36);
		add_text("-");
		repeat (12) add_text("z");                    // 36^12 - 1 still fits
		add_pin("z", sitp_pkg::NEG_LIMIT, 16'd13, 1'b1); // overflow stops at this digit
		plan.push_back('{1'b0, sitp_pkg::CH_NUL, 1'b0, sitp_pkg::result_t'(0)});
		add_cfg(6'd1);                                // base 1 takes only zeros
		add_text("0");
		add_pin("1", '0, 16'd1, 1'b0);
		plan.push_back('{1'b0, sitp_pkg::CH_NUL, 1'b0, sitp_pkg::result_t'(0)});
		add_cfg(6'd63);                               // above 36, used as given
		add_text("Z9");
		plan.push_back('{1'b0, sitp_pkg::CH_NUL, 1'b0, sitp_pkg::result_t'(0)});
		add_cfg(sitp_pkg::BASE_HEX);                  // prefix skipped in base 16
		add_text("0Xf");
		plan.push_back('{1'b0, sitp_pkg::CH_NUL, 1'b0, sitp_pkg::result_t'(0)});
		add_cfg(sitp_pkg::BASE_DEC);                  // radix changed mid-string
		add_text("1");
		add_cfg(6'd2);
		add_text("9");
		plan.push_back('{1'b0, sitp_pkg::CH_NUL, 1'b0, sitp_pkg::result_t'(0)});
		plan.push_back('{1'b0, sitp_pkg::CH_CR, 1'b0, sitp_pkg::result_t'(0)});
		add_text("1012");                             // base 2, stops at the 2
		plan.push_back('{1'b0, sitp_pkg::CH_NUL, 1'b0, sitp_pkg::result_t'(0)});

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_radix(plan[i].data[sitp_pkg::RADIX_W-1:0]);
			else begin
				pinned_q.push_back('{plan[i].pinned, plan[i].res});
				send_char(plan[i].data);
			end
		end

		// --- random part, one radix per phase ---
		phase_no = 0;
		while (counted < RAND_ITEMS) begin
			write_radix((phase_no < 9) ? radix_plan[phase_no] :
				sitp_pkg::RADIX_W'($urandom_range(63)));
			// long receiver hold-off while the sender keeps offering beats
			if (phase_no == 2)
				hold_req <= 1'b1;
			phase_end = counted + PHASE_ITEMS;
			while (counted < phase_end) begin
				send_gap_pct = (counted < 400) ? 27 : (counted < 800) ? 46 : 0;
				recv_gap_pct = (counted < 400) ? 46 : (counted < 800) ? 27 : 0;
				build_string();
				foreach (text_q[i])
					send_char(text_q[i]);
			end
			phase_no++;
		end

		drain(8);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
